>>> rtl/poll_master_retry_reporter_assert.svh
`ifndef POLL_MASTER_RETRY_REPORTER_ASSERT_SVH
`define POLL_MASTER_RETRY_REPORTER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define PMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define PMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pmr_pkg.sv
package pmr_pkg;

    localparam int MAX_CLIENTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ERR_SLOTS       = 8;
    localparam int S_DATA_W        = 104;
    localparam int M_DATA_W        = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_IDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDR  = 2'd3;

    localparam logic [3:0]  CLIENT_COUNT_RST = 4'd2;
    localparam logic [63:0] CLIENT_IDS_RST   = 64'd10537;
    localparam logic [7:0]  MAX_RETRIES_RST  = 8'd8;
    localparam logic [7:0]  SERVER_ADDR_RST  = 8'd0;

    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_RESPONSE = 1'b1;
    localparam logic KIND_POLL    = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [7:0] ACT_GET   = 8'h01;
    localparam logic [7:0] STATE_OK  = 8'h01;
    localparam logic [1:0] ERR_LIMIT = 2'd3;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;

    typedef struct packed {
        logic        has_rpt;
        logic        has_poll;
        logic [7:0]  poll_id;
        logic [7:0]  rpt_id;
        logic        rpt_err;
        logic [7:0]  rpt_state;
        logic [15:0] hum;
        logic [15:0] tmp;
        logic [7:0]  status;
    } job_t;

endpackage

>>> rtl/pmr_digits.sv
module pmr_digits (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] value,
    output logic        done,
    output logic [6:0]  dig0,
    output logic [3:0]  dig1,
    output logic [3:0]  dig2,
    output logic [3:0]  dig3
);
    localparam logic [2:0] STEP_Q1000 = 3'd0;
    localparam logic [2:0] STEP_R1000 = 3'd1;
    localparam logic [2:0] STEP_Q100  = 3'd2;
    localparam logic [2:0] STEP_R100  = 3'd3;
    localparam logic [2:0] STEP_Q10   = 3'd4;
    localparam logic [2:0] STEP_R10   = 3'd5;
    localparam logic [2:0] STEP_DONE  = 3'd6;

    logic [2:0]  step_reg, step_next;
    logic [15:0] rem_reg, rem_next;
    logic [6:0]  d0_reg, d0_next;
    logic [3:0]  d1_reg, d1_next;
    logic [3:0]  d2_reg, d2_next;
    logic [3:0]  d3_reg, d3_next;
    logic [32:0] prod_k;
    logic [25:0] prod_h;
    logic [22:0] prod_t;
    logic [15:0] last_rem;

    // reciprocal multiplies, exact for the value ranges seen at each step
    assign prod_k   = {17'd0, rem_reg} * 33'd67109;
    assign prod_h   = {10'd0, rem_reg} * 26'd656;
    assign prod_t   = {7'd0, rem_reg} * 23'd103;
    assign last_rem = rem_reg - ({12'd0, d2_reg} * 16'd10);

    always_comb begin
        step_next = step_reg;
        rem_next  = rem_reg;
        d0_next   = d0_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        d3_next   = d3_reg;
        if (start) begin
            rem_next  = value;
            step_next = STEP_Q1000;
        end else begin
            case (step_reg)
                STEP_Q1000: begin
                    d0_next   = prod_k[32:26];
                    step_next = STEP_R1000;
                end
                STEP_R1000: begin
                    rem_next  = rem_reg - ({9'd0, d0_reg} * 16'd1000);
                    step_next = STEP_Q100;
                end
                STEP_Q100: begin
                    d1_next   = prod_h[19:16];
                    step_next = STEP_R100;
                end
                STEP_R100: begin
                    rem_next  = rem_reg - ({12'd0, d1_reg} * 16'd100);
                    step_next = STEP_Q10;
                end
                STEP_Q10: begin
                    d2_next   = prod_t[13:10];
                    step_next = STEP_R10;
                end
                STEP_R10: begin
                    d3_next   = last_rem[3:0];
                    step_next = STEP_DONE;
                end
                default: begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_DONE;
        end else begin
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        d3_reg  <= d3_next;
    end

    assign done = (step_reg == STEP_DONE);
    assign dig0 = d0_reg;
    assign dig1 = d1_reg;
    assign dig2 = d2_reg;
    assign dig3 = d3_reg;

endmodule

>>> rtl/pmr_queue.sv
module pmr_queue #(
    parameter int DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pmr_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output pmr_pkg::job_t out_job
);
    import pmr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != (AW + 1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_job;
        end
    end

endmodule

>>> rtl/pmr_front.sv
module pmr_front #(
    parameter int MAX_CLIENTS = pmr_pkg::MAX_CLIENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           req_type,
    input  logic [7:0]                     dest_addr,
    input  logic [7:0]                     source_id,
    input  logic [7:0]                     action,
    input  logic [7:0]                     rsp_state,
    input  logic                           parity_error,
    input  logic [31:0]                    humidity_bytes,
    input  logic [31:0]                    temperature_bytes,
    output logic                           job_valid,
    input  logic                           job_ready,
    output pmr_pkg::job_t                  job
);
    import pmr_pkg::*;

    localparam logic [3:0] MAX_SLOT = 4'(MAX_CLIENTS);

    function automatic logic [7:0] id_of(input logic [63:0] ids, input logic [3:0] slot);
        logic [3:0] m;
        m = slot - 4'd1;
        return ids[{m[2:0], 3'b000} +: 8];
    endfunction

    function automatic logic [15:0] pack_value(input logic [31:0] b);
        logic [18:0] s;
        s = ({11'd0, b[31:24]} * 19'd1000) + ({11'd0, b[23:16]} * 19'd100)
          + ({11'd0, b[15:8]} * 19'd10) + {11'd0, b[7:0]};
        return s[15:0];
    endfunction

    logic [3:0]  client_count_reg;
    logic [63:0] client_ids_reg;
    logic [7:0]  max_retries_reg;
    logic [7:0]  server_addr_reg;

    logic [3:0]  slot_reg, slot_next;
    logic        seen_reg, seen_next;
    logic [7:0]  retry_reg, retry_next;
    logic [1:0]  err_cnt_reg [ERR_SLOTS];
    logic [1:0]  err_cnt_next [ERR_SLOTS];
    logic [7:0]  status_reg, status_next;

    logic        accept;
    logic [3:0]  eff_count;
    logic [7:0]  cur_id;
    logic        rsp_match;
    logic [7:0]  retry_inc;
    logic [3:0]  poll_slot;
    logic        poll_do;
    logic        rpt_req;
    logic        rpt_do;
    logic [7:0]  rpt_id;
    logic        rpt_err;
    logic [7:0]  rpt_state;
    logic [15:0] rpt_hum;
    logic [15:0] rpt_tmp;
    logic [2:0]  eidx;
    logic [1:0]  err_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = job_ready;
    assign accept    = s_valid && job_ready;
    assign eff_count = (client_count_reg > MAX_SLOT) ? MAX_SLOT : client_count_reg;
    assign cur_id    = id_of(client_ids_reg, slot_reg);
    assign retry_inc = retry_reg + 8'd1;
    assign rsp_match = (dest_addr == server_addr_reg) && !parity_error
                    && (slot_reg != 4'd0) && (source_id == cur_id);

    always_comb begin
        slot_next    = slot_reg;
        seen_next    = seen_reg;
        retry_next   = retry_reg;
        err_cnt_next = err_cnt_reg;
        status_next  = status_reg;
        poll_slot    = slot_reg;
        poll_do      = 1'b0;
        rpt_req      = 1'b0;
        rpt_do       = 1'b0;
        rpt_id       = cur_id;
        rpt_err      = 1'b1;
        rpt_state    = 8'd0;
        rpt_hum      = 16'd0;
        rpt_tmp      = 16'd0;
        eidx         = 3'd0;
        err_inc      = 2'd0;
        if (accept) begin
            if (req_type == REQ_TICK) begin
                if ((slot_reg != 4'd0) && !seen_reg) begin
                    if (retry_inc >= max_retries_reg) begin
                        rpt_req    = 1'b1;
                        poll_slot  = slot_reg + 4'd1;
                        retry_next = 8'd0;
                    end else begin
                        retry_next = retry_inc;
                    end
                end else begin
                    if (slot_reg != 4'd0) begin
                        poll_slot = slot_reg + 4'd1;
                    end
                    retry_next = 8'd0;
                end
                if ((poll_slot == 4'd0) || (poll_slot > eff_count)) begin
                    poll_slot = 4'd1;
                end
                slot_next = poll_slot;
                seen_next = 1'b0;
                poll_do   = 1'b1;
            end else if (rsp_match) begin
                seen_next = 1'b1;
                if (action == ACT_GET) begin
                    rpt_req   = 1'b1;
                    rpt_id    = source_id;
                    rpt_err   = 1'b0;
                    rpt_state = rsp_state;
                    rpt_hum   = pack_value(humidity_bytes);
                    rpt_tmp   = pack_value(temperature_bytes);
                end
            end
            if (rpt_req) begin
                eidx    = rpt_id[2:0];
                err_inc = err_cnt_reg[eidx] + 2'd1;
                if (!rpt_err) begin
                    err_cnt_next[eidx] = 2'd0;
                    rpt_do             = 1'b1;
                end else if (err_inc >= ERR_LIMIT) begin
                    err_cnt_next[eidx] = 2'd0;
                    rpt_do             = 1'b1;
                end else begin
                    err_cnt_next[eidx] = err_inc;
                end
                if (rpt_do) begin
                    status_next[eidx] = !((rpt_state == STATE_OK) && !rpt_err);
                end
            end
        end
    end

    always_comb begin
        job.has_rpt   = rpt_do;
        job.has_poll  = poll_do;
        job.poll_id   = id_of(client_ids_reg, poll_slot);
        job.rpt_id    = rpt_id;
        job.rpt_err   = rpt_err;
        job.rpt_state = rpt_state;
        job.hum       = rpt_hum;
        job.tmp       = rpt_tmp;
        job.status    = status_next;
    end

    assign job_valid = accept && (rpt_do || poll_do);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_count_reg <= CLIENT_COUNT_RST;
            client_ids_reg   <= CLIENT_IDS_RST;
            max_retries_reg  <= MAX_RETRIES_RST;
            server_addr_reg  <= SERVER_ADDR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CLIENT_COUNT: client_count_reg <= cfg_data[3:0];
                REG_CLIENT_IDS:   client_ids_reg   <= cfg_data;
                REG_MAX_RETRIES:  max_retries_reg  <= cfg_data[7:0];
                REG_SERVER_ADDR:  server_addr_reg  <= cfg_data[7:0];
                default:          client_count_reg <= client_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= 4'd0;
            seen_reg   <= 1'b0;
            retry_reg  <= 8'd0;
            status_reg <= 8'hFF;
            for (int i = 0; i < ERR_SLOTS; i++) begin
                err_cnt_reg[i] <= 2'd0;
            end
        end else begin
            slot_reg    <= slot_next;
            seen_reg    <= seen_next;
            retry_reg   <= retry_next;
            status_reg  <= status_next;
            err_cnt_reg <= err_cnt_next;
        end
    end

endmodule

>>> rtl/pmr_back.sv
module pmr_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  pmr_pkg::job_t                job,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pmr_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import pmr_pkg::*;

    localparam logic [4:0] IDX_A         = 5'd0;
    localparam logic [4:0] IDX_B         = 5'd1;
    localparam logic [4:0] IDX_C         = 5'd2;
    localparam logic [4:0] IDX_ID        = 5'd3;
    localparam logic [4:0] IDX_ERR       = 5'd4;
    localparam logic [4:0] IDX_STATE     = 5'd5;
    localparam logic [4:0] IDX_HUM0      = 5'd6;
    localparam logic [4:0] IDX_HUM1      = 5'd7;
    localparam logic [4:0] IDX_HUM2      = 5'd8;
    localparam logic [4:0] IDX_HUM3      = 5'd9;
    localparam logic [4:0] IDX_TMP0      = 5'd10;
    localparam logic [4:0] IDX_TMP1      = 5'd11;
    localparam logic [4:0] IDX_TMP2      = 5'd12;
    localparam logic [4:0] IDX_TMP3      = 5'd13;
    localparam logic [4:0] IDX_D         = 5'd14;
    localparam logic [4:0] IDX_RPT_LAST  = 5'd15;
    localparam logic [4:0] IDX_POLL_ID   = 5'd16;
    localparam logic [4:0] IDX_POLL_LAST = 5'd17;

    job_t       job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [4:0] idx_reg, idx_next;
    logic       tvalid_reg, tvalid_next;
    logic [7:0] byte_reg, byte_next;
    logic       kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [7:0] status_reg, status_next;

    logic       load, out_free, digits_ok, emit;
    logic [7:0] sel_byte;
    logic       hum_done, tmp_done;
    logic [6:0] hum_d0, tmp_d0;
    logic [3:0] hum_d1, hum_d2, hum_d3;
    logic [3:0] tmp_d1, tmp_d2, tmp_d3;

    assign job_ready = !busy_reg;
    assign load      = job_valid && !busy_reg;
    assign out_free  = !tvalid_reg || m_tready;
    assign digits_ok = (idx_reg < IDX_HUM0) || (idx_reg > IDX_TMP3) || (hum_done && tmp_done);
    assign emit      = busy_reg && out_free && digits_ok;

    pmr_digits u_hum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (load),
        .value   (job.hum),
        .done    (hum_done),
        .dig0    (hum_d0),
        .dig1    (hum_d1),
        .dig2    (hum_d2),
        .dig3    (hum_d3)
    );

    pmr_digits u_tmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (load),
        .value   (job.tmp),
        .done    (tmp_done),
        .dig0    (tmp_d0),
        .dig1    (tmp_d1),
        .dig2    (tmp_d2),
        .dig3    (tmp_d3)
    );

    always_comb begin
        case (idx_reg)
            IDX_A:         sel_byte = CH_A;
            IDX_B:         sel_byte = CH_B;
            IDX_C:         sel_byte = CH_C;
            IDX_ID:        sel_byte = job_reg.rpt_id;
            IDX_ERR:       sel_byte = {7'd0, job_reg.rpt_err};
            IDX_STATE:     sel_byte = job_reg.rpt_state;
            IDX_HUM0:      sel_byte = {1'b0, hum_d0};
            IDX_HUM1:      sel_byte = {4'd0, hum_d1};
            IDX_HUM2:      sel_byte = {4'd0, hum_d2};
            IDX_HUM3:      sel_byte = {4'd0, hum_d3};
            IDX_TMP0:      sel_byte = {1'b0, tmp_d0};
            IDX_TMP1:      sel_byte = {4'd0, tmp_d1};
            IDX_TMP2:      sel_byte = {4'd0, tmp_d2};
            IDX_TMP3:      sel_byte = {4'd0, tmp_d3};
            IDX_D:         sel_byte = CH_D;
            IDX_RPT_LAST:  sel_byte = CH_E;
            IDX_POLL_ID:   sel_byte = job_reg.poll_id;
            IDX_POLL_LAST: sel_byte = ACT_GET;
            default:       sel_byte = 8'd0;
        endcase
    end

    always_comb begin
        job_next    = job_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg;
        byte_next   = byte_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        status_next = status_reg;
        if (load) begin
            busy_next = 1'b1;
            job_next  = job;
            idx_next  = job.has_rpt ? IDX_A : IDX_POLL_ID;
        end
        if (emit) begin
            tvalid_next = 1'b1;
            byte_next   = sel_byte;
            kind_next   = (idx_reg >= IDX_POLL_ID) ? KIND_POLL : KIND_REPORT;
            last_next   = (idx_reg == IDX_RPT_LAST) || (idx_reg == IDX_POLL_LAST);
            status_next = job_reg.status;
            if ((idx_reg == IDX_POLL_LAST) ||
                ((idx_reg == IDX_RPT_LAST) && !job_reg.has_poll)) begin
                busy_next = 1'b0;
            end else if (idx_reg == IDX_RPT_LAST) begin
                idx_next = IDX_POLL_ID;
            end else begin
                idx_next = idx_reg + 5'd1;
            end
        end else if (out_free) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            idx_reg    <= IDX_A;
            tvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
        end
        job_reg    <= job_next;
        byte_reg   <= byte_next;
        kind_reg   <= kind_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = {status_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/poll_master_retry_reporter.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: response fields; tuser: req_type
// m_        out  m_tvalid/m_tready  tdata: out_byte, client_status; tuser: frame_kind
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// An input word is taken every cycle while the 4-entry job queue has room.
// Output runs one word per cycle per job unless m_tready or the digits stall it:
// 2 for a poll, 16 for a report, 18 for a failed poll slot, once the job is loaded.
// Report digits come from a reciprocal divider that overlaps the header.
// aresetn is synchronous; it restores register defaults and sets all status bits.
module poll_master_retry_reporter #(
    parameter int MAX_CLIENTS = pmr_pkg::MAX_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dest_addr, source_id, action, rsp_state, parity_error,
    // humidity_bytes, temperature_bytes, zero fill
    input  logic [pmr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pmr_pkg::M_DATA_W-1:0]   m_tdata,   // out_byte, client_status
    output logic                           m_tuser,   // frame_kind
    output logic                           m_tlast    // frame_last
);
    import pmr_pkg::*;

    job_t front_job, queue_job;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    pmr_front #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_tvalid),
        .s_ready           (s_tready),
        .req_type          (s_tuser),
        .dest_addr         (s_tdata[7:0]),
        .source_id         (s_tdata[15:8]),
        .action            (s_tdata[23:16]),
        .rsp_state         (s_tdata[31:24]),
        .parity_error      (s_tdata[32]),
        .humidity_bytes    (s_tdata[64:33]),
        .temperature_bytes (s_tdata[96:65]),
        .job_valid         (front_valid),
        .job_ready         (front_ready),
        .job               (front_job)
    );

    pmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_job   (queue_job)
    );

    pmr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .job       (queue_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/pmr_port_checker.sv
`include "poll_master_retry_reporter_assert.svh"

module pmr_port_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pmr_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);
    import pmr_pkg::*;

    `PMR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")
    `PMR_ASSERT_NOW(a_poll_end, m_tvalid && (m_tuser == KIND_POLL) && m_tlast, m_tdata[7:0] == ACT_GET, "poll frame does not end in get action")
    `PMR_ASSERT_NOW(a_report_end, m_tvalid && (m_tuser == KIND_REPORT) && m_tlast, m_tdata[7:0] == CH_E, "report frame does not end in trailer byte")
    `PMR_ASSERT_NEXT(a_frame_steady, m_tvalid && m_tready && !m_tlast, !m_tvalid || ((m_tdata[15:8] == $past(m_tdata[15:8])) && (m_tuser == $past(m_tuser))), "status or kind changed inside a frame")

endmodule

bind poll_master_retry_reporter pmr_port_checker u_port_checker (.*);

>>> tb/tb_poll_master_retry_reporter.sv
module tb_poll_master_retry_reporter;
    import pmr_pkg::*;

    localparam int STUCK_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       kind;
        logic       last;
        logic [7:0] status;
    } out_word_t;

    class retry_report_board;
        logic [3:0]  count_reg;
        logic [63:0] ids_reg;
        logic [7:0]  retries_reg;
        logic [7:0]  server_reg;
        logic [3:0]  slot;
        logic        seen;
        logic [7:0]  retry;
        logic [1:0]  err_run [8];
        logic [7:0]  status;
        out_word_t   batch [$];
        out_word_t   due_words [$];
        int          errors;

        function new();
            count_reg   = CLIENT_COUNT_RST;
            ids_reg     = CLIENT_IDS_RST;
            retries_reg = MAX_RETRIES_RST;
            server_reg  = SERVER_ADDR_RST;
            slot        = 4'd0;
            seen        = 1'b0;
            retry       = 8'd0;
            foreach (err_run[i]) err_run[i] = 2'd0;
            status      = 8'hFF;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CLIENT_COUNT: count_reg   = data[3:0];
                REG_CLIENT_IDS:   ids_reg     = data;
                REG_MAX_RETRIES:  retries_reg = data[7:0];
                REG_SERVER_ADDR:  server_reg  = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] slot_client(logic [3:0] s);
            int idx;
            idx = (int'(s) - 1) & 7;
            return ids_reg[8*idx +: 8];
        endfunction

        function logic [7:0] polled_client();
            return (slot == 4'd0) ? 8'h00 : slot_client(slot);
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function logic [15:0] digit_value(logic [31:0] b);
            int v;
            v = int'(b[31:24]) * 1000 + int'(b[23:16]) * 100 + int'(b[15:8]) * 10
                + int'(b[7:0]);
            return v[15:0];
        endfunction

        function void push_word(logic [7:0] b, logic kind, logic last);
            out_word_t w;
            w.data_byte = b;
            w.kind      = kind;
            w.last      = last;
            w.status    = 8'h00;
            batch.push_back(w);
        endfunction

        function void file_report(logic [7:0] client, logic err, logic [7:0] state,
                                  logic [15:0] hum, logic [15:0] tmp);
            int         idx;
            int         h;
            int         t;
            logic [7:0] rpt [16];
            idx = client[2:0];
            h   = hum;
            t   = tmp;
            if (!err) begin
                err_run[idx] = 2'd0;
            end else begin
                err_run[idx] = err_run[idx] + 2'd1;
                if (err_run[idx] >= ERR_LIMIT) begin
                    err_run[idx] = 2'd0;
                end else begin
                    return;
                end
            end
            status[idx] = !(state == STATE_OK && !err);
            rpt[0]  = CH_A;
            rpt[1]  = CH_B;
            rpt[2]  = CH_C;
            rpt[3]  = client;
            rpt[4]  = {7'd0, err};
            rpt[5]  = state;
            rpt[6]  = 8'(h / 1000);
            rpt[7]  = 8'(h % 1000 / 100);
            rpt[8]  = 8'(h % 100 / 10);
            rpt[9]  = 8'(h % 10);
            rpt[10] = 8'(t / 1000);
            rpt[11] = 8'(t % 1000 / 100);
            rpt[12] = 8'(t % 100 / 10);
            rpt[13] = 8'(t % 10);
            rpt[14] = CH_D;
            rpt[15] = CH_E;
            foreach (rpt[i]) push_word(rpt[i], KIND_REPORT, i == 15);
        endfunction

        function void note_word(logic req, logic [7:0] dest, logic [7:0] src,
                                logic [7:0] act, logic [7:0] state, logic par,
                                logic [31:0] hum, logic [31:0] tmp);
            logic [3:0] lim;
            batch.delete();
            if (req == REQ_TICK) begin
                if (slot != 4'd0 && !seen) begin
                    retry = retry + 8'd1;
                    if (retry >= retries_reg) begin
                        file_report(slot_client(slot), 1'b1, 8'd0, 16'd0, 16'd0);
                        seen  = 1'b1;
                        slot  = slot + 4'd1;
                        retry = 8'd0;
                    end
                end else begin
                    if (slot != 4'd0) slot = slot + 4'd1;
                    retry = 8'd0;
                end
                lim = (count_reg > MAX_CLIENTS_DEF) ? 4'(MAX_CLIENTS_DEF) : count_reg;
                if (slot == 4'd0 || slot > lim) slot = 4'd1;
                push_word(slot_client(slot), KIND_POLL, 1'b0);
                push_word(ACT_GET, KIND_POLL, 1'b1);
                seen = 1'b0;
            end else if (dest == server_reg && !par && slot != 4'd0
                         && src == slot_client(slot)) begin
                seen = 1'b1;
                if (act == ACT_GET)
                    file_report(src, 1'b0, state, digit_value(hum), digit_value(tmp));
            end
            foreach (batch[i]) begin
                batch[i].status = status;
                due_words.push_back(batch[i]);
            end
        endfunction

        function void check_word(logic [7:0] b, logic [7:0] st, logic kind, logic last);
            out_word_t w;
            if (due_words.size() == 0) begin
                $error("unexpected word: out_byte %0h client_status %0h frame_kind %0b",
                       b, st, kind);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (b !== w.data_byte) begin
                $error("out_byte: expected %0h, got %0h", w.data_byte, b);
                errors++;
            end
            if (st !== w.status) begin
                $error("client_status: expected %0h, got %0h", w.status, st);
                errors++;
            end
            if (kind !== w.kind) begin
                $error("frame_kind: expected %0b, got %0b", w.kind, kind);
                errors++;
            end
            if (last !== w.last) begin
                $error("frame_last: expected %0b, got %0b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    retry_report_board board;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic              hold_request;
    int                stuck_cycles;

    poll_master_retry_reporter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_word(m_tdata[7:0], m_tdata[15:8], m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [3:0] count, input logic [63:0] ids,
                             input logic [7:0] retries, input logic [7:0] server);
        write_reg(REG_CLIENT_COUNT, {60'd0, count});
        write_reg(REG_CLIENT_IDS, ids);
        write_reg(REG_MAX_RETRIES, {56'd0, retries});
        write_reg(REG_SERVER_ADDR, {56'd0, server});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic req, input logic [7:0] dest, input logic [7:0] src,
                             input logic [7:0] act, input logic [7:0] state, input logic par,
                             input logic [31:0] hum, input logic [31:0] tmp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, tmp, hum, par, state, act, src, dest};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_word(req, dest, src, act, state, par, hum, tmp);
        @(negedge aclk);
    endtask

    task automatic tick();
        send_item(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 32'd0, 32'd0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] digit_bytes();
        if ($urandom_range(99) < 70)
            return {8'($urandom_range(65)), 8'($urandom_range(9)), 8'($urandom_range(9)),
                    8'($urandom_range(9))};
        return $urandom();
    endfunction

    task automatic run_random(input int n);
        int          pick;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [7:0]  act;
        logic [7:0]  state;
        logic        par;
        for (int i = 0; i < n; i++) begin
            pick  = $urandom_range(99);
            dest  = board.server_reg;
            src   = board.polled_client();
            act   = ($urandom_range(9) != 0) ? ACT_GET : 8'($urandom());
            state = ($urandom_range(3) != 0) ? STATE_OK : 8'($urandom());
            par   = 1'b0;
            if (pick < 35) begin
                send_item(REQ_TICK, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                          8'($urandom()), 1'($urandom()), $urandom(), $urandom());
            end else begin
                if (pick >= 80) begin
                    case ($urandom_range(3))
                        0: dest = 8'($urandom());
                        1: par = 1'b1;
                        2: src = 8'($urandom());
                        default: begin
                            dest = 8'($urandom());
                            src  = 8'($urandom());
                            par  = 1'($urandom());
                        end
                    endcase
                end
                send_item(REQ_RESPONSE, dest, src, act, state, par, digit_bytes(),
                          digit_bytes());
            end
        end
    endtask

    initial begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        stuck_cycles   = 0;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_TICK;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults: two clients, both with id 41, server 0
        send_item(REQ_RESPONSE, 8'd0, 8'd40, ACT_GET, STATE_OK, 1'b0, 32'd0, 32'd0);
        tick();
        send_item(REQ_RESPONSE, 8'd0, 8'd40, ACT_GET, STATE_OK, 1'b0, 32'h09090909, 32'd0);
        send_item(REQ_RESPONSE, 8'd0, 8'd40, ACT_GET, 8'd0, 1'b0, 32'hFFFFFFFF, 32'h41000000);
        send_item(REQ_RESPONSE, 8'd0, 8'd40, 8'h02, STATE_OK, 1'b0, 32'd0, 32'd0);
        tick();
        send_item(REQ_RESPONSE, 8'd0, 8'd41, ACT_GET, STATE_OK, 1'b1, 32'd0, 32'd0);
        send_item(REQ_RESPONSE, 8'hFF, 8'd41, ACT_GET, STATE_OK, 1'b0, 32'd0, 32'd0);
        send_item(REQ_RESPONSE, 8'd0, 8'd40, ACT_GET, STATE_OK, 1'b0, 32'd0, 32'd0);
        tick();
        send_item(REQ_RESPONSE, 8'd0, 8'd41, ACT_GET, 8'hFF, 1'b0, 32'h01020304, 32'hFFFFFFFF);
        tick();
        drain_results();

        // zero count and zero retry limit: every slot fails at once
        configure(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'hFF);
        repeat (4) tick();
        send_item(REQ_RESPONSE, 8'hFF, 8'hFF, ACT_GET, STATE_OK, 1'b0, 32'h09090909,
                  32'h09090909);
        drain_results();

        // count above the maximum saturates
        configure(4'd15, 64'h0F0E_0D0C_0B0A_0908, 8'd1, 8'd0);
        repeat (4) tick();
        drain_results();

        configure(4'd1, {$urandom(), $urandom()}, 8'd1, 8'($urandom()));
        run_random(33);
        drain_results();

        configure(4'd8, {$urandom(), $urandom()}, 8'd255, 8'd0);
        send_idle_pct = 88;
        run_random(33);
        drain_results();

        configure(4'd15, 64'd0, 8'd2, 8'($urandom()));
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        hold_request   = 1'b1;
        run_random(33);
        drain_results();

        configure(4'($urandom_range(1, 8)), {$urandom(), $urandom()}, 8'($urandom_range(1, 4)),
                  8'($urandom()));
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        run_random(33);
        drain_results();

        configure(4'd3, {$urandom(), $urandom()}, 8'd3, 8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(33);
        drain_results();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
